### hw/rtl/trial_division_prime_test_core_defines.svh
// assertion macros for the trial division prime test core
`ifndef TRIAL_DIVISION_PRIME_TEST_CORE_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_CORE_DEFINES_SVH

// same cycle implication
`define TDPT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tdpt assertion failed");

// next cycle implication
`define TDPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tdpt assertion failed");

`endif

### hw/rtl/tdpt_pkg.sv
`default_nettype none

package tdpt_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);
   localparam int SQ_WIDTH    = VALUE_WIDTH + 1;

   typedef enum logic [1:0] {
      VERDICT_NEITHER,
      VERDICT_COMPOSITE,
      VERDICT_PRIME
   } verdict_type;

endpackage

`default_nettype wire

### hw/rtl/trial_division_prime_test_core.sv
// negative, small and even values: the accepted beat goes through ST_CHECK to ST_DONE,
// which registers the result once the output is free; odd values try the divisors
// 3, 5, 7 and so on in turn through ST_TRIAL and ST_DIV, a prime ending on the failing
// bound check in ST_TRIAL; ST_DIV is a bit-serial remainder unit, one dividend bit per cycle
// throughput: one item at a time, the next beat is taken once the result is registered
// reset: synchronous, active high, clears the sequencer and the result valid
`default_nettype none

module trial_division_prime_test_core
   import tdpt_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [1:0]                         rsp_verdict
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_TRIAL,
      ST_DIV,
      ST_DONE
   } state_type;

   localparam logic [CNT_WIDTH-1:0] LAST_BIT = CNT_WIDTH'(VALUE_WIDTH - 1);

   state_type              state_ff, state_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [VALUE_WIDTH-1:0] div_ff, div_in;
   logic [SQ_WIDTH-1:0]    sq_ff, sq_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] shift_ff, shift_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   verdict_type            verdict_ff, verdict_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   verdict_type            rsp_verdict_ff, rsp_verdict_in;

   logic [VALUE_WIDTH:0]   shifted;
   logic                   fits;
   logic [VALUE_WIDTH-1:0] rem_next;
   logic                   out_free;

   always_comb begin
      shifted  = {rem_ff, shift_ff[VALUE_WIDTH-1]};
      fits     = shifted >= {1'b0, div_ff};
      rem_next = fits ? VALUE_WIDTH'(shifted - {1'b0, div_ff}) : shifted[VALUE_WIDTH-1:0];
      out_free = !rsp_valid_ff || !rsp_stall;

      state_in       = state_ff;
      value_in       = value_ff;
      div_in         = div_ff;
      sq_in          = sq_ff;
      rem_in         = rem_ff;
      shift_in       = shift_ff;
      cnt_in         = cnt_ff;
      verdict_in     = verdict_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_verdict_in = rsp_verdict_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               value_in = req_value;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (value_ff[VALUE_WIDTH-1] || value_ff <= VALUE_WIDTH'(1)) begin
               verdict_in = VERDICT_NEITHER;
               state_in   = ST_DONE;
            end else if (value_ff == VALUE_WIDTH'(2)) begin
               verdict_in = VERDICT_PRIME;
               state_in   = ST_DONE;
            end else if (!value_ff[0]) begin
               verdict_in = VERDICT_COMPOSITE;
               state_in   = ST_DONE;
            end else begin
               div_in   = VALUE_WIDTH'(3);
               sq_in    = SQ_WIDTH'(9);
               state_in = ST_TRIAL;
            end
         end
         ST_TRIAL: begin
            if (sq_ff > {1'b0, value_ff}) begin
               verdict_in = VERDICT_PRIME;
               state_in   = ST_DONE;
            end else begin
               rem_in   = '0;
               shift_in = value_ff;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in   = rem_next;
            shift_in = {shift_ff[VALUE_WIDTH-2:0], 1'b0};
            cnt_in   = cnt_ff + CNT_WIDTH'(1);
            if (cnt_ff == LAST_BIT) begin
               if (rem_next == '0) begin
                  verdict_in = VERDICT_COMPOSITE;
                  state_in   = ST_DONE;
               end else begin
                  // (d + 2)^2 = d^2 + 4d + 4
                  div_in   = div_ff + VALUE_WIDTH'(2);
                  sq_in    = sq_ff + SQ_WIDTH'({div_ff, 2'b00}) + SQ_WIDTH'(4);
                  state_in = ST_TRIAL;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = verdict_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff       <= value_in;
      div_ff         <= div_in;
      sq_ff          <= sq_in;
      rem_ff         <= rem_in;
      shift_ff       <= shift_in;
      cnt_ff         <= cnt_in;
      verdict_ff     <= verdict_in;
      rsp_verdict_ff <= rsp_verdict_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall   = state_ff != ST_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;

endmodule

`default_nettype wire

### hw/rtl/tdpt_checker.sv
`default_nettype none
`include "trial_division_prime_test_core_defines.svh"

module tdpt_checker
   import tdpt_pkg::*;
(
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic signed [VALUE_WIDTH-1:0] req_value,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [1:0]                    rsp_verdict
);

   // a taken beat makes the core busy
   `TDPT_ASSERT_NEXT(a_busy_after_beat, clock, reset, req_valid && !req_stall, req_stall)
   // only the three verdict codes ever appear
   `TDPT_ASSERT_NOW(a_verdict_code, clock, reset, rsp_valid, rsp_verdict == VERDICT_NEITHER || rsp_verdict == VERDICT_COMPOSITE || rsp_verdict == VERDICT_PRIME)
   // a stalled result beat stays
   `TDPT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `TDPT_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_verdict))

endmodule

bind trial_division_prime_test_core tdpt_checker u_tdpt_checker (.*);

`default_nettype wire

### dv/tb_trial_division_prime_test_core.sv
`timescale 1ns / 1ps

module tb_trial_division_prime_test_core;
   import tdpt_pkg::*;

   localparam int DRAIN_CYCLES = 20;

   logic                          clock     = 1'b0;
   logic                          reset     = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [VALUE_WIDTH-1:0] req_value = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [1:0]                    rsp_verdict;

   verdict_type expected_verdicts[$];
   int          error_count = 0;
   bit          idling_on   = 1'b1;
   int          stall_left  = 0;

   trial_division_prime_test_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_value   (req_value),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_verdict (rsp_verdict)
   );

   always #6 clock = ~clock;

   function automatic verdict_type predict_verdict(input logic signed [VALUE_WIDTH-1:0] v);
      logic [63:0] mag;
      logic [63:0] d;
      mag = '0;
      mag[VALUE_WIDTH-1:0] = v;
      if (v[VALUE_WIDTH-1]) return VERDICT_NEITHER;
      if (mag <= 64'd1) return VERDICT_NEITHER;
      if (mag == 64'd2) return VERDICT_PRIME;
      if (!mag[0]) return VERDICT_COMPOSITE;
      for (d = 64'd3; d <= mag / d; d = d + 64'd2) begin
         if (mag % d == 64'd0) return VERDICT_COMPOSITE;
      end
      return VERDICT_PRIME;
   endfunction

   // mostly small values so the run stays short; wide noise only where it is even or negative
   function automatic logic signed [VALUE_WIDTH-1:0] random_value();
      logic [31:0] r;
      logic [31:0] p;
      logic [31:0] q;
      r = $urandom;
      case ($urandom_range(0, 9))
         0: begin
            if (!r[31] && r[0] && r > 32'd262144) r[0] = 1'b0;
         end
         1: r = 32'($urandom_range(0, 48)) - 32'd8;
         7: r = $urandom_range(4096, 262144);
         8: begin
            p = $urandom_range(3, 1023) | 32'd1;
            q = $urandom_range(3, 1023) | 32'd1;
            r = p * q;
         end
         9: r = {1'b0, r[30:1], 1'b0};
         default: r = $urandom_range(3, 4095);
      endcase
      return r;
   endfunction

   task automatic send_value(input logic signed [VALUE_WIDTH-1:0] v);
      int gap;
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (req_stall);
      expected_verdicts.push_back(predict_verdict(v));
      gap = 0;
      if (idling_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_value <= $urandom;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic test_extremes();
      send_value(32'sh7fff_ffff);
      send_value(32'sh7fff_fffe);
      send_value(32'sh7fff_fffd);
      send_value(32'sh7fff_fffb);
      send_value(32'sh8000_0000);
      send_value(-32'sd1);
      send_value(-32'sd2);
      send_value(32'shaaaa_aaaa);
      send_value(32'sh5555_5555);
   endtask

   task automatic test_small_values();
      send_value(32'sd0);
      send_value(32'sd1);
      send_value(32'sd2);
      send_value(32'sd3);
      send_value(32'sd4);
      send_value(32'sd5);
      send_value(32'sd97);
      send_value(32'sd7919);
      send_value(32'sd65536);
      send_value(32'sd65537);
   endtask

   // divisor at or just below the square root bound
   task automatic test_prime_squares();
      send_value(32'sd9);
      send_value(32'sd25);
      send_value(32'sd49);
      send_value(32'sd10201);
      send_value(32'sd10403);
   endtask

   task automatic test_random_with_idling();
      repeat (60) send_value(random_value());
   endtask

   task automatic test_random_back_to_back();
      idling_on = 1'b0;
      repeat (20) send_value(random_value());
   endtask

   always @(posedge clock) begin
      if (idling_on && stall_left == 0 && $urandom_range(0, 3) == 0) begin
         stall_left <= $urandom_range(1, 5) - 1;
         rsp_stall  <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      verdict_type exp_verdict;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_verdicts.size() == 0) begin
            $display("%0t: unexpected result beat, expected none actual verdict %0d",
                     $time, rsp_verdict);
            error_count++;
         end else begin
            exp_verdict = expected_verdicts.pop_front();
            if (rsp_verdict !== exp_verdict) begin
               $display("%0t: verdict mismatch, expected %0d actual %0d",
                        $time, exp_verdict, rsp_verdict);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_small_values();
      test_prime_squares();
      test_extremes();
      test_random_with_idling();
      test_random_back_to_back();
      req_valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("trial_division_prime_test_core test passed");
      end else begin
         $display("trial_division_prime_test_core test failed");
      end
      $finish;
   end

   initial begin
      #250_000_000;
      $display("trial_division_prime_test_core test failed");
      $finish;
   end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/tdpt_pkg.sv
hw/rtl/trial_division_prime_test_core.sv
hw/rtl/tdpt_checker.sv
dv/tb_trial_division_prime_test_core.sv
